// File: hdl/dem_hillshade_pixel_top_defines.svh
// ----------------------------------------------------------------------------
// dem_hillshade_pixel_top_defines.svh
// Assertion macros shared by the hillshade block.
// ----------------------------------------------------------------------------
`ifndef DEM_HILLSHADE_PIXEL_TOP_DEFINES_SVH
`define DEM_HILLSHADE_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DHS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define DHS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/dhs_pkg.sv
// ----------------------------------------------------------------------------
// dhs_pkg
// Types, widths and constants shared by the hillshade block.
// ----------------------------------------------------------------------------
package dhs_pkg;

    // Line buffer geometry
    localparam int MAX_WIDTH  = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int H_W        = 17;
    localparam int SMP_W      = 18;

    // Job queue between front and back
    localparam int Q_DEPTH    = 4;
    localparam int QA_W       = $clog2(Q_DEPTH);
    localparam int QC_W       = $clog2(Q_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Shading datapath widths
    localparam int MUL_W      = 26;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MAG_W      = 47;
    localparam int NORM_BITS  = 24;
    localparam int ACC_W      = 44;
    localparam int SQ_W       = 50;
    localparam int ROOT_W     = 25;
    localparam int DIV_W      = SQ_W + 8;
    localparam int DIV_CNT_W  = 4;

    // Register reset values
    localparam logic [19:0]        RST_U_SCALE = 20'd256;
    localparam logic [19:0]        RST_V_SCALE = 20'd256;
    localparam logic signed [15:0] RST_LIGHT_X = 16'sd11585;
    localparam logic signed [15:0] RST_LIGHT_Y = 16'sd0;
    localparam logic signed [15:0] RST_LIGHT_Z = 16'sd11585;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_U_SCALE    = 3'd0,
        REG_V_SCALE    = 3'd1,
        REG_LIGHT_X    = 3'd2,
        REG_LIGHT_Y    = 3'd3,
        REG_LIGHT_Z    = 3'd4,
        REG_NODATA_EN  = 3'd5,
        REG_NODATA_LVL = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [19:0]        u_scale;
        logic [19:0]        v_scale;
        logic signed [15:0] light_x;
        logic signed [15:0] light_y;
        logic signed [15:0] light_z;
        logic               nodata_en;
        logic [H_W-1:0]     nodata_lvl;
    } cfg_t;

    // One shading request: sample bit 17 is the valid flag
    typedef struct packed {
        logic [SMP_W-1:0] ctr;
        logic [SMP_W-1:0] rgt;
        logic [SMP_W-1:0] low;
        logic             row_end;
        logic             frame_end;
        logic             last;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_RD,
        F_EMIT
    } front_state_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_M0,
        B_M1,
        B_M2,
        B_M3,
        B_NORM,
        B_D0,
        B_D1,
        B_D2,
        B_D3,
        B_S1,
        B_S2,
        B_S3,
        B_SQN,
        B_L0,
        B_L1,
        B_L2,
        B_L3,
        B_SQL,
        B_DEN,
        B_DIV0,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

// File: hdl/dem_hillshade_pixel_top.sv
// ----------------------------------------------------------------------------
// dem_hillshade_pixel_top
// Hillshade of a raster elevation stream with one-row line buffer.
// ----------------------------------------------------------------------------
// Each accepted pixel holds the front until its requests are out: the accept,
// a line-buffer read that builds the requests (F_RD), then a turn for each of
// the three request slots (F_EMIT), used or not, plus any time spent waiting
// on a full queue. A pixel causes zero to three shade requests. A request
// whose samples are all valid goes through the back unit's normalizing shifts,
// its single shared 26x26 multiplier (13 products), two 25-step square roots
// and a 9-step restoring divide, and then holds at the output until taken. A
// dark or degenerate result skips the divide; a request with a masked sample
// goes straight to the output. A four-entry request queue lets the front take
// the next pixel while the back works. Output lags input by one row; the image's
// last row also yields its own results.
module dem_hillshade_pixel_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wen,
    input  logic [dhs_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [dhs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [dhs_pkg::H_W-1:0]     s_height,
    input  logic                               s_height_valid,
    input  logic                               s_row_end,
    input  logic                               s_final_row,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_shade,
    output logic                               m_shade_valid,
    output logic                               m_out_row_end,
    output logic                               m_out_frame_end,
    output logic                               m_run_last
);
    import dhs_pkg::*;

    cfg_t cfg_reg;
    job_t f_job, b_job;
    logic q_push, q_full, q_pop, q_empty;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.u_scale    <= RST_U_SCALE;
            cfg_reg.v_scale    <= RST_V_SCALE;
            cfg_reg.light_x    <= RST_LIGHT_X;
            cfg_reg.light_y    <= RST_LIGHT_Y;
            cfg_reg.light_z    <= RST_LIGHT_Z;
            cfg_reg.nodata_en  <= 1'b0;
            cfg_reg.nodata_lvl <= '0;
        end else if (cfg_wen) begin
            case (cfg_idx)
                REG_U_SCALE:    cfg_reg.u_scale    <= cfg_wdata;
                REG_V_SCALE:    cfg_reg.v_scale    <= cfg_wdata;
                REG_LIGHT_X:    cfg_reg.light_x    <= cfg_wdata[15:0];
                REG_LIGHT_Y:    cfg_reg.light_y    <= cfg_wdata[15:0];
                REG_LIGHT_Z:    cfg_reg.light_z    <= cfg_wdata[15:0];
                REG_NODATA_EN:  cfg_reg.nodata_en  <= cfg_wdata[0];
                REG_NODATA_LVL: cfg_reg.nodata_lvl <= cfg_wdata[H_W-1:0];
                default: ;
            endcase
        end
    end

    dhs_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_height       (s_height),
        .s_height_valid (s_height_valid),
        .s_row_end      (s_row_end),
        .s_final_row    (s_final_row),
        .q_data         (f_job),
        .q_push         (q_push),
        .q_full         (q_full)
    );

    dhs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (f_job),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (b_job),
        .empty   (q_empty)
    );

    dhs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_data          (b_job),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_shade         (m_shade),
        .m_shade_valid   (m_shade_valid),
        .m_out_row_end   (m_out_row_end),
        .m_out_frame_end (m_out_frame_end),
        .m_run_last      (m_run_last)
    );

endmodule

// File: hdl/dhs_queue.sv
// ----------------------------------------------------------------------------
// dhs_queue
// Small request queue between the line-buffer front and the shading back.
// ----------------------------------------------------------------------------
`include "dem_hillshade_pixel_top_defines.svh"

module dhs_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  dhs_pkg::job_t din,
    output logic         full,
    input  logic         pop,
    output dhs_pkg::job_t dout,
    output logic         empty
);
    import dhs_pkg::*;

    job_t             buf_reg [Q_DEPTH];
    logic [QA_W-1:0]  wr_ptr_reg;
    logic [QA_W-1:0]  rd_ptr_reg;
    logic [QC_W-1:0]  count_reg;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_ptr_reg] <= din;
    end

    assign dout  = buf_reg[rd_ptr_reg];
    assign full  = (count_reg == QC_W'(Q_DEPTH));
    assign empty = (count_reg == '0);

    `DHS_ASSERT_IMP(a_no_overflow, push, !full, "request pushed into full queue")
    `DHS_ASSERT_IMP(a_no_underflow, pop, !empty, "request popped from empty queue")
    `DHS_ASSERT_NXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count did not grow")

endmodule

// File: hdl/dhs_front.sv
// ----------------------------------------------------------------------------
// dhs_front
// Accepts samples, masks them, keeps the upper row and issues shading requests.
// ----------------------------------------------------------------------------
module dhs_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dhs_pkg::cfg_t               cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dhs_pkg::H_W-1:0]     s_height,
    input  logic                        s_height_valid,
    input  logic                        s_row_end,
    input  logic                        s_final_row,
    output dhs_pkg::job_t               q_data,
    output logic                        q_push,
    input  logic                        q_full
);
    import dhs_pkg::*;

    front_state_t     state_reg, state_next;
    logic [COL_W-1:0] column_reg;
    logic [COL_W-1:0] col_lat_reg;
    logic             have_upper_reg;
    logic [SMP_W-1:0] left_reg;
    logic [SMP_W-1:0] cur_reg;
    logic             re_reg;
    logic             fr_reg;
    logic [SMP_W-1:0] rd_a_reg;
    logic [SMP_W-1:0] rd_b_reg;
    job_t             job0_reg, job1_reg, job2_reg;
    logic [2:0]       en_reg;
    logic [1:0]       slot_reg;
    logic [SMP_W-1:0] mem [MAX_WIDTH];

    logic             accept;
    logic             advance;
    logic             slot_en;
    logic             vld;
    logic [COL_W-1:0] col_inc;
    logic [SMP_W-1:0] upr;

    assign accept  = s_valid && s_ready;
    assign col_inc = column_reg + 1'b1;
    assign vld     = s_height_valid && !(cfg.nodata_en && (s_height == cfg.nodata_lvl));
    assign upr     = re_reg ? rd_a_reg : rd_b_reg;

    // Line buffer: two reads at accept, write back in the following cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_a_reg <= mem[column_reg];
            rd_b_reg <= mem[col_inc];
        end
        if (state_reg == F_RD) mem[col_lat_reg] <= cur_reg;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= F_IDLE;
            column_reg     <= '0;
            have_upper_reg <= 1'b0;
            left_reg       <= '0;
            en_reg         <= '0;
            slot_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == F_RD) begin
                en_reg[0] <= have_upper_reg;
                en_reg[1] <= fr_reg && (col_lat_reg != '0);
                en_reg[2] <= fr_reg && re_reg;
                slot_reg  <= '0;
                left_reg  <= cur_reg;
                if (re_reg) begin
                    column_reg     <= '0;
                    have_upper_reg <= !fr_reg;
                end else begin
                    column_reg <= col_lat_reg + 1'b1;
                end
            end else if (advance) begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    // Request capture and job build
    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_reg     <= {vld, s_height};
            re_reg      <= s_row_end || (column_reg == COL_W'(MAX_WIDTH - 1));
            fr_reg      <= s_final_row;
            col_lat_reg <= column_reg;
        end
        if (state_reg == F_RD) begin
            job0_reg <= '{ctr: rd_a_reg, rgt: upr, low: cur_reg, row_end: re_reg,
                          frame_end: 1'b0,
                          last: !(fr_reg && ((col_lat_reg != '0) || re_reg))};
            job1_reg <= '{ctr: left_reg, rgt: cur_reg, low: left_reg, row_end: 1'b0,
                          frame_end: 1'b0, last: !re_reg};
            job2_reg <= '{ctr: cur_reg, rgt: cur_reg, low: cur_reg, row_end: 1'b1,
                          frame_end: 1'b1, last: 1'b1};
        end
    end

    // Slot select
    always_comb begin
        case (slot_reg)
            2'd0: begin
                q_data  = job0_reg;
                slot_en = en_reg[0];
            end
            2'd1: begin
                q_data  = job1_reg;
                slot_en = en_reg[1];
            end
            2'd2: begin
                q_data  = job2_reg;
                slot_en = en_reg[2];
            end
            default: begin
                q_data  = job2_reg;
                slot_en = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (accept) state_next = F_RD;
            F_RD:   state_next = F_EMIT;
            F_EMIT: if (advance && (slot_reg == 2'd2)) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready = (state_reg == F_IDLE);
        q_push  = (state_reg == F_EMIT) && slot_en && !q_full;
        advance = (state_reg == F_EMIT) && (!slot_en || !q_full);
    end

endmodule

// File: hdl/dhs_back.sv
// ----------------------------------------------------------------------------
// dhs_back
// Shading unit: normal, normalization, dot product, norms and scaled quotient
// on one shared multiplier and one bit-serial square root.
// ----------------------------------------------------------------------------
module dhs_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  dhs_pkg::cfg_t     cfg,
    input  dhs_pkg::job_t     q_data,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_shade,
    output logic              m_shade_valid,
    output logic              m_out_row_end,
    output logic              m_out_frame_end,
    output logic              m_run_last
);
    import dhs_pkg::*;

    back_state_t             state_reg, state_next;
    job_t                    job_reg;
    logic signed [SMP_W-1:0] dz1_reg, dz2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [2:0]              sgn_reg;
    logic [MAG_W-1:0]        mag_reg [3];
    logic signed [ACC_W-1:0] acc_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [SQ_W-1:0]         rem_reg, r_reg, bit_reg;
    logic [ROOT_W-1:0]       nn_reg, nl_reg;
    logic [SQ_W-1:0]         den_reg, num_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic [8:0]              quot_reg;
    logic [7:0]              shade_reg;
    logic                    shv_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_abs;
    logic [SQ_W-1:0]          r_bit, r_next, rem_next;
    logic                     sq_ge;
    logic [DIV_W-1:0]         trial;
    logic                     div_ge;
    logic [8:0]               quot_next;
    logic                     need_norm;
    logic                     all_valid;

    // Signed normal component from sign and magnitude
    function automatic logic signed [MUL_W-1:0] nval(input logic s, input logic [MAG_W-1:0] m);
        logic signed [MUL_W-1:0] t;
        t = $signed({2'b00, m[NORM_BITS-1:0]});
        return s ? -t : t;
    endfunction

    assign prod_abs  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign need_norm = (|mag_reg[0][MAG_W-1:NORM_BITS]) || (|mag_reg[1][MAG_W-1:NORM_BITS])
                       || (|mag_reg[2][MAG_W-1:NORM_BITS]);
    assign all_valid = q_data.ctr[SMP_W-1] && q_data.rgt[SMP_W-1] && q_data.low[SMP_W-1];

    // Square root step
    assign r_bit    = r_reg + bit_reg;
    assign sq_ge    = (rem_reg >= r_bit);
    assign r_next   = sq_ge ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);
    assign rem_next = sq_ge ? (rem_reg - r_bit) : rem_reg;

    // Restoring division step
    assign trial     = {8'b0, den_reg} << cnt_reg;
    assign div_ge    = ({8'b0, num_reg} >= trial);
    assign quot_next = quot_reg | (div_ge ? (9'd1 << cnt_reg) : 9'd0);

    // Shared multiplier, registered
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            B_M0: begin
                mul_a = $signed({6'b0, cfg.v_scale});
                mul_b = MUL_W'(dz1_reg);
            end
            B_M1: begin
                mul_a = $signed({6'b0, cfg.u_scale});
                mul_b = MUL_W'(dz2_reg);
            end
            B_M2: begin
                mul_a = $signed({6'b0, cfg.u_scale});
                mul_b = $signed({6'b0, cfg.v_scale});
            end
            B_D0: begin
                mul_a = nval(sgn_reg[0], mag_reg[0]);
                mul_b = MUL_W'(cfg.light_x);
            end
            B_D1: begin
                mul_a = nval(sgn_reg[1], mag_reg[1]);
                mul_b = MUL_W'(cfg.light_y);
            end
            B_D2: begin
                mul_a = nval(sgn_reg[2], mag_reg[2]);
                mul_b = MUL_W'(cfg.light_z);
            end
            B_D3: begin
                mul_a = nval(sgn_reg[0], mag_reg[0]);
                mul_b = nval(sgn_reg[0], mag_reg[0]);
            end
            B_S1: begin
                mul_a = nval(sgn_reg[1], mag_reg[1]);
                mul_b = nval(sgn_reg[1], mag_reg[1]);
            end
            B_S2: begin
                mul_a = nval(sgn_reg[2], mag_reg[2]);
                mul_b = nval(sgn_reg[2], mag_reg[2]);
            end
            B_L0: begin
                mul_a = MUL_W'(cfg.light_x);
                mul_b = MUL_W'(cfg.light_x);
            end
            B_L1: begin
                mul_a = MUL_W'(cfg.light_y);
                mul_b = MUL_W'(cfg.light_y);
            end
            B_L2: begin
                mul_a = MUL_W'(cfg.light_z);
                mul_b = MUL_W'(cfg.light_z);
            end
            B_DEN: begin
                mul_a = $signed({1'b0, nn_reg});
                mul_b = $signed({1'b0, nl_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= B_IDLE;
        else          state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    job_reg   <= q_data;
                    dz1_reg   <= $signed({q_data.rgt[H_W-1], q_data.rgt[H_W-1:0]})
                               - $signed({q_data.ctr[H_W-1], q_data.ctr[H_W-1:0]});
                    dz2_reg   <= $signed({q_data.low[H_W-1], q_data.low[H_W-1:0]})
                               - $signed({q_data.ctr[H_W-1], q_data.ctr[H_W-1:0]});
                    shade_reg <= 8'd0;
                    shv_reg   <= 1'b0;
                end
            end
            B_M1, B_M2: begin
                // n = -(scale * dz) * 256
                sgn_reg[state_reg == B_M2] <= !prod_reg[PROD_W-1] && (prod_reg != '0);
                mag_reg[state_reg == B_M2] <= {prod_abs[MAG_W-9:0], 8'b0};
            end
            B_M3: begin
                sgn_reg[2] <= 1'b0;
                mag_reg[2] <= prod_reg[MAG_W-1:0];
            end
            B_NORM: begin
                if (need_norm) begin
                    mag_reg[0] <= mag_reg[0] >> 1;
                    mag_reg[1] <= mag_reg[1] >> 1;
                    mag_reg[2] <= mag_reg[2] >> 1;
                end
            end
            B_D1: acc_reg <= prod_reg[ACC_W-1:0];
            B_D2: acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            B_D3: acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            B_S1, B_L1: sq_reg <= prod_reg[SQ_W-1:0];
            B_S2, B_L2: sq_reg <= sq_reg + prod_reg[SQ_W-1:0];
            B_S3, B_L3: begin
                rem_reg <= sq_reg + prod_reg[SQ_W-1:0];
                r_reg   <= '0;
                bit_reg <= SQ_W'(1) << (SQ_W - 2);
            end
            B_SQN, B_SQL: begin
                rem_reg <= rem_next;
                r_reg   <= r_next;
                bit_reg <= bit_reg >> 2;
                if (bit_reg == SQ_W'(1)) begin
                    if (state_reg == B_SQN) nn_reg <= r_next[ROOT_W-1:0];
                    else                    nl_reg <= r_next[ROOT_W-1:0];
                end
            end
            B_DIV0: begin
                den_reg   <= prod_reg[SQ_W-1:0];
                num_reg   <= {SQ_W'(acc_reg) << 8} - SQ_W'(acc_reg);
                cnt_reg   <= DIV_CNT_W'(8);
                quot_reg  <= '0;
                shade_reg <= 8'd0;
                shv_reg   <= 1'b1;
            end
            B_DIV: begin
                if (div_ge) num_reg <= num_reg - trial[SQ_W-1:0];
                quot_reg <= quot_next;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == '0) shade_reg <= quot_next[8] ? 8'hFF : quot_next[7:0];
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (!q_empty) state_next = all_valid ? B_M0 : B_OUT;
            B_M0:   state_next = B_M1;
            B_M1:   state_next = B_M2;
            B_M2:   state_next = B_M3;
            B_M3:   state_next = B_NORM;
            B_NORM: if (!need_norm) state_next = B_D0;
            B_D0:   state_next = B_D1;
            B_D1:   state_next = B_D2;
            B_D2:   state_next = B_D3;
            B_D3:   state_next = B_S1;
            B_S1:   state_next = B_S2;
            B_S2:   state_next = B_S3;
            B_S3:   state_next = B_SQN;
            B_SQN:  if (bit_reg == SQ_W'(1)) state_next = B_L0;
            B_L0:   state_next = B_L1;
            B_L1:   state_next = B_L2;
            B_L2:   state_next = B_L3;
            B_L3:   state_next = B_SQL;
            B_SQL:  if (bit_reg == SQ_W'(1)) state_next = B_DEN;
            B_DEN:  state_next = B_DIV0;
            // Dark side or degenerate norm gives zero shade
            B_DIV0: state_next = (acc_reg[ACC_W-1] || (acc_reg == '0) || (prod_reg == '0))
                                 ? B_OUT : B_DIV;
            B_DIV:  if (cnt_reg == '0) state_next = B_OUT;
            B_OUT:  if (m_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        q_pop           = (state_reg == B_IDLE) && !q_empty;
        m_valid         = (state_reg == B_OUT);
        m_shade         = shade_reg;
        m_shade_valid   = shv_reg;
        m_out_row_end   = job_reg.row_end;
        m_out_frame_end = job_reg.frame_end;
        m_run_last      = job_reg.last;
    end

endmodule
